@@ src/fpalu_pkg.sv @@
// types, constants and the divider step shared by the fixed-point alu
// depends on nothing
package fpalu_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int WORD_BITS     = 32;

    localparam int OP_W    = 4;
    localparam int FIELD_W = 32;

    localparam int S_FIELDS_W = OP_W + 2 * FIELD_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = FIELD_W + 4;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int A_LSB = OP_W;
    localparam int B_LSB = OP_W + FIELD_W;

    localparam int LT_BIT = FIELD_W;
    localparam int EQ_BIT = FIELD_W + 1;
    localparam int GT_BIT = FIELD_W + 2;
    localparam int DZ_BIT = FIELD_W + 3;

    // quotient bits resolved per divider stage
    localparam int BITS_PER_STAGE = 4;
    localparam int QUOT_BITS      = WORD_BITS + FRACTION_BITS;
    localparam int DIV_STAGES     = (QUOT_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int NUM_W          = DIV_STAGES * BITS_PER_STAGE;

    // input, compute, divider stages, output
    localparam int N_STAGES = DIV_STAGES + 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_COMPARE  = 4'd4,
        OP_MIN      = 4'd5,
        OP_MAX      = 4'd6,
        OP_INC      = 4'd7,
        OP_DEC      = 4'd8,
        OP_TO_INT   = 4'd9,
        OP_FROM_INT = 4'd10
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [WORD_BITS-1:0] simple;
        logic [2*WORD_BITS-1:0]     prod;
        logic                       lt;
        logic                       eq;
        logic                       gt;
        logic                       dz;
        logic                       neg;
        logic [WORD_BITS-1:0]       den;
        logic [WORD_BITS-1:0]       rem;
        logic [NUM_W-1:0]           num;
    } pipe_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] rem;
        logic [NUM_W-1:0]     num;
    } div_state_t;

    // restoring division, quotient bits shift into the numerator word
    function automatic div_state_t div_step(input div_state_t st,
                                            input logic [WORD_BITS-1:0] den);
        div_state_t         s;
        logic [WORD_BITS:0] trial;
        s = st;
        for (int i = 0; i < BITS_PER_STAGE; i++) begin
            trial = {s.rem, s.num[NUM_W-1]};
            s.num = {s.num[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den}) begin
                trial    = trial - {1'b0, den};
                s.num[0] = 1'b1;
            end
            s.rem = trial[WORD_BITS-1:0];
        end
        return s;
    endfunction

endpackage

@@ src/fixed_point_alu_core.sv @@
// signed fixed-point alu, pipelined with a radix-16 restoring divider
// depends on fpalu_pkg
//
// usage:
//   s_ channel takes one item per operation: op, operand a and operand b in
//   s_tdata. m_ channel returns one item per accepted input: the raw result,
//   the signed compare flags of a against b and a divide-by-zero flag.
//   results leave in the order the operations came in.
// path: every op passes the input stage, the compute stage, the divider stages
//   and the output stage on its way to m_tvalid; the depth is set by the divider,
//   which resolves four quotient bits per stage.
// throughput: one item per cycle while m_tready is high, every stage holds its own item.
// reset: aresetn low clears every stage valid; nothing is in flight after.
// stall: when m_tready is low the output stage holds its item; stages behind
//   it keep filling bubbles and s_tready only drops once every stage is full.
//   nothing is lost or repeated.
// multiply keeps the full product and shifts right arithmetically; divide
//   truncates toward zero and gives zero when b is zero. all results wrap.
module fixed_point_alu_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // op [3:0], operand_a [35:4], operand_b [67:36], zero pad
    input  logic [fpalu_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result [31:0], less [32], equal [33], greater [34], divide_by_zero [35], zero pad
    output logic [fpalu_pkg::M_TDATA_W-1:0] m_tdata
);
    import fpalu_pkg::*;

    localparam int LAST = N_STAGES - 1;

    logic [N_STAGES-1:0] valid_reg;
    logic [N_STAGES-1:0] rdy;

    op_t                         op_reg;
    logic signed [WORD_BITS-1:0] a_reg;
    logic signed [WORD_BITS-1:0] b_reg;
    op_t                         op_next;
    logic signed [WORD_BITS-1:0] a_next;
    logic signed [WORD_BITS-1:0] b_next;

    pipe_t pipe_reg  [0:DIV_STAGES];
    pipe_t pipe_next [0:DIV_STAGES];

    logic [M_TDATA_W-1:0] out_reg;
    logic [M_TDATA_W-1:0] out_next;

    logic signed [2*WORD_BITS-1:0] prod_full;
    logic [WORD_BITS-1:0]          mag_a;
    logic [WORD_BITS-1:0]          mag_b;
    logic signed [WORD_BITS-1:0]   res_word;
    logic [WORD_BITS-1:0]          quot;
    div_state_t                    ds_in  [1:DIV_STAGES];
    div_state_t                    ds_out [1:DIV_STAGES];

    // ready chain, from the output back
    always_comb begin
        rdy[LAST] = !valid_reg[LAST] || m_tready;
        for (int i = LAST - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[LAST];
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < N_STAGES; i++) begin
                if (rdy[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // input stage
    always_comb begin
        op_next = op_t'(s_tdata[OP_W-1:0]);
        a_next  = WORD_BITS'(signed'(s_tdata[A_LSB +: FIELD_W]));
        b_next  = WORD_BITS'(signed'(s_tdata[B_LSB +: FIELD_W]));
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            op_reg <= op_next;
            a_reg  <= a_next;
            b_reg  <= b_next;
        end
    end

    // compute stage: product, flags, simple ops, divider set-up
    always_comb begin
        prod_full = a_reg * b_reg;
        mag_a     = a_reg[WORD_BITS-1] ? WORD_BITS'(-a_reg) : WORD_BITS'(a_reg);
        mag_b     = b_reg[WORD_BITS-1] ? WORD_BITS'(-b_reg) : WORD_BITS'(b_reg);

        pipe_next[0].op   = op_reg;
        pipe_next[0].prod = prod_full;
        pipe_next[0].lt   = a_reg < b_reg;
        pipe_next[0].eq   = a_reg == b_reg;
        pipe_next[0].gt   = a_reg > b_reg;
        pipe_next[0].dz   = (op_reg == OP_DIV) && (b_reg == '0);
        pipe_next[0].neg  = a_reg[WORD_BITS-1] ^ b_reg[WORD_BITS-1];
        pipe_next[0].den  = mag_b;
        pipe_next[0].rem  = '0;
        pipe_next[0].num  = NUM_W'(mag_a) << FRACTION_BITS;

        case (op_reg)
            OP_ADD:      pipe_next[0].simple = a_reg + b_reg;
            OP_SUB:      pipe_next[0].simple = a_reg - b_reg;
            OP_MIN:      pipe_next[0].simple = (a_reg < b_reg) ? a_reg : b_reg;
            OP_MAX:      pipe_next[0].simple = (a_reg > b_reg) ? a_reg : b_reg;
            OP_INC:      pipe_next[0].simple = a_reg + WORD_BITS'(1);
            OP_DEC:      pipe_next[0].simple = a_reg - WORD_BITS'(1);
            OP_TO_INT:   pipe_next[0].simple = a_reg >>> FRACTION_BITS;
            OP_FROM_INT: pipe_next[0].simple = a_reg <<< FRACTION_BITS;
            default:     pipe_next[0].simple = '0;
        endcase
    end

    // divider stages
    always_comb begin
        for (int k = 1; k <= DIV_STAGES; k++) begin
            ds_in[k].rem = pipe_reg[k-1].rem;
            ds_in[k].num = pipe_reg[k-1].num;
            ds_out[k]    = div_step(ds_in[k], pipe_reg[k-1].den);
            pipe_next[k]     = pipe_reg[k-1];
            pipe_next[k].rem = ds_out[k].rem;
            pipe_next[k].num = ds_out[k].num;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k <= DIV_STAGES; k++) begin
            if (rdy[k+1]) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    // output stage
    always_comb begin
        quot = pipe_reg[DIV_STAGES].num[WORD_BITS-1:0];
        case (pipe_reg[DIV_STAGES].op)
            OP_MUL:  res_word = pipe_reg[DIV_STAGES].prod[FRACTION_BITS +: WORD_BITS];
            OP_DIV: begin
                if (pipe_reg[DIV_STAGES].dz) begin
                    res_word = '0;
                end else if (pipe_reg[DIV_STAGES].neg) begin
                    res_word = -quot;
                end else begin
                    res_word = quot;
                end
            end
            default: res_word = pipe_reg[DIV_STAGES].simple;
        endcase
        out_next                 = '0;
        out_next[FIELD_W-1:0]    = FIELD_W'(res_word);
        out_next[LT_BIT]         = pipe_reg[DIV_STAGES].lt;
        out_next[EQ_BIT]         = pipe_reg[DIV_STAGES].eq;
        out_next[GT_BIT]         = pipe_reg[DIV_STAGES].gt;
        out_next[DZ_BIT]         = pipe_reg[DIV_STAGES].dz;
    end

    always_ff @(posedge aclk) begin
        if (rdy[LAST]) begin
            out_reg <= out_next;
        end
    end

    // checks
    a_flags_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tdata[GT_BIT:LT_BIT]))
        else $error("compare flags not one-hot");

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[DZ_BIT]) |-> (m_tdata[FIELD_W-1:0] == '0))
        else $error("divide by zero with non-zero result");

    a_full_only: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output not blocked");

    a_dz_eq: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[1] && pipe_reg[0].dz) |-> (pipe_reg[0].den == '0))
        else $error("divide by zero flag without zero divisor");

endmodule
